FILE: hw/rtl/segment_reorder_receiver_macros.svh
// Assertion macros for the segment reorder receiver.
`ifndef SEGMENT_REORDER_RECEIVER_MACROS_SVH
`define SEGMENT_REORDER_RECEIVER_MACROS_SVH
`ifndef SYNTHESIS
`define SRR_ASSERT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("srr assertion failed");
`define SRR_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("srr assertion failed");
`else
`define SRR_ASSERT(label, ante, cons)
`define SRR_ASSERT_NEXT(label, ante, cons)
`endif
`endif

FILE: hw/rtl/srr_pkg.sv
// Types and constants shared by the segment reorder receiver modules.
package srr_pkg;

	localparam int SEQ_W = 32;
	localparam int LEN_W = 9;
	localparam int TAG_W = 8;

	localparam logic RES_DELIVER = 1'b0;
	localparam logic RES_ACK     = 1'b1;

	typedef struct packed {
		logic [SEQ_W-1:0] seq_number;
		logic [LEN_W-1:0] payload_length;
		logic [TAG_W-1:0] payload_tag;
		logic             final_segment;
	} seg_in_t;

	typedef struct packed {
		logic             result_kind;
		logic [SEQ_W-1:0] ack_number;
		logic [TAG_W-1:0] deliver_tag;
		logic [LEN_W-1:0] deliver_length;
		logic             deliver_fin;
		logic             dropped;
		logic             transfer_done;
		logic             last_result;
	} seg_out_t;

	// payload fields of a stored early segment
	typedef struct packed {
		logic [LEN_W-1:0] length;
		logic [TAG_W-1:0] tag;
		logic             fin;
	} slot_data_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_SEARCH,
		ST_DELIV,
		ST_ACK
	} back_state_t;

endpackage

FILE: hw/rtl/segment_reorder_receiver.sv
// Top level of the segment reorder receiver.
`include "segment_reorder_receiver_macros.svh"

// Receive-side reorder buffer. Each accepted segment header yields zero or more
// in-order delivery items followed by one acknowledgement item (last_result set).
// Headers enter a two-deep queue, so two more can be accepted while one is being
// worked on. A header goes through dequeue, classify, stored-slot search and
// acknowledge; early, late or zero-length segments skip the search. Each stored
// segment that is drained adds a slot search and the registered read of the slot
// payload RAM. Output stalls hold the classify, drain and acknowledge steps. Stored
// segments left behind the expected byte stay in their slots: a late segment with
// the same number is neither stored nor delivered, so it does not clear them.
module segment_reorder_receiver #(
	parameter int REORDER_SLOTS = 8,
	parameter int MAX_PAYLOAD   = 500,
	parameter int TAG_BITS      = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              seg_valid,
	output logic              seg_stall,
	input  srr_pkg::seg_in_t  seg,
	output logic              res_valid,
	input  logic              res_stall,
	output srr_pkg::seg_out_t res
);
	import srr_pkg::*;

	logic    head_valid;
	seg_in_t head;
	logic    pop;

	srr_front #(
		.MAX_PAYLOAD(MAX_PAYLOAD),
		.TAG_BITS   (TAG_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.seg_valid  (seg_valid),
		.seg_stall  (seg_stall),
		.seg        (seg),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop)
	);

	srr_back #(
		.REORDER_SLOTS(REORDER_SLOTS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.res        (res)
	);

	// only the acknowledgement closes an item's results
	`SRR_ASSERT(a_last_is_ack, res_valid, (res.result_kind == RES_ACK) == res.last_result)
	`SRR_ASSERT(a_deliver_clean, res_valid && (res.result_kind == RES_DELIVER), (res.ack_number == '0) && !res.dropped && !res.transfer_done)
	`SRR_ASSERT(a_ack_clean, res_valid && (res.result_kind == RES_ACK), (res.deliver_tag == '0) && (res.deliver_length == '0) && !res.deliver_fin)
	`SRR_ASSERT(a_len_capped, res_valid, 17'(res.deliver_length) <= 17'(MAX_PAYLOAD))
	`SRR_ASSERT_NEXT(a_done_sticky, res_valid && !res_stall && (res.result_kind == RES_ACK) && res.transfer_done, !res_valid || (res.result_kind == RES_DELIVER) || res.transfer_done)
endmodule

FILE: hw/rtl/srr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module srr_ram #(
	parameter int WIDTH = 18,
	parameter int DEPTH = 8
) (
	input  logic                                     clk,
	input  logic                                     wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                         wr_data,
	input  logic                                     rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                         rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;
endmodule

FILE: hw/rtl/srr_front.sv
// Front end: takes segment headers, clamps length, masks tag, queues them.
module srr_front #(
	parameter int MAX_PAYLOAD = 500,
	parameter int TAG_BITS    = 8
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            seg_valid,
	output logic            seg_stall,
	input  srr_pkg::seg_in_t seg,
	output logic            head_valid,
	output srr_pkg::seg_in_t head,
	input  logic            pop
);
	import srr_pkg::*;

	localparam int LEN_CAP = (MAX_PAYLOAD < 511) ? MAX_PAYLOAD : 511;
	localparam logic [15:0] TAG_MASK = 16'((32'd1 << TAG_BITS) - 32'd1);

	seg_in_t     prepped;
	seg_in_t     fifo_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  count_q;
	logic        push;

	always_comb begin
		prepped = seg;
		if (17'(seg.payload_length) > 17'(MAX_PAYLOAD)) begin
			prepped.payload_length = LEN_W'(LEN_CAP);
		end
		prepped.payload_tag = seg.payload_tag & TAG_MASK[TAG_W-1:0];
	end

	assign seg_stall  = (count_q == 2'd2);
	assign push       = seg_valid && !seg_stall;
	assign head_valid = (count_q != 2'd0);
	assign head       = fifo_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop && head_valid) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop && head_valid})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= prepped;
		end
	end
endmodule

FILE: hw/rtl/srr_back.sv
// Back end: classifies queued segments, stores early ones (drops them when no slot is free), drains in order.
module srr_back #(
	parameter int REORDER_SLOTS = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             head_valid,
	input  srr_pkg::seg_in_t head,
	output logic             pop,
	output logic             res_valid,
	input  logic             res_stall,
	output srr_pkg::seg_out_t res
);
	import srr_pkg::*;

	localparam int N     = REORDER_SLOTS;
	localparam int IDX_W = (N > 1) ? $clog2(N) : 1;

	back_state_t       state_q, state_d;
	seg_in_t           item_q;
	logic [SEQ_W-1:0]  expected_q;
	logic              finished_q;
	logic              drop_q;
	logic [N-1:0]      slot_valid_q;
	logic [SEQ_W-1:0]  slot_seq_q [N];
	logic              res_valid_q;
	seg_out_t          res_q;

	logic [N-1:0]      seq_hit, exp_hit;
	logic              seq_any, free_any, exp_any;
	logic [IDX_W-1:0]  seq_idx, free_idx, exp_idx, pick_idx;
	logic              in_order, early, out_free;
	logic              do_eval, store, drop_set, deliver_item, read_slot;
	logic              deliver_slot, send_ack, emit, deliver_any;
	logic [LEN_W-1:0]  del_len;
	logic              del_fin;
	seg_out_t          emit_data;
	slot_data_t        wr_slot, rd_slot;
	logic [$bits(slot_data_t)-1:0] rd_raw;

	// slot number compare, two comparators per slot
	always_comb begin
		for (int i = 0; i < N; i++) begin
			seq_hit[i] = slot_valid_q[i] && (slot_seq_q[i] == item_q.seq_number);
			exp_hit[i] = slot_valid_q[i] && (slot_seq_q[i] == expected_q);
		end
	end

	// lowest-index pick
	always_comb begin
		seq_idx  = '0;
		free_idx = '0;
		exp_idx  = '0;
		for (int i = N - 1; i >= 0; i--) begin
			if (seq_hit[i]) begin
				seq_idx = IDX_W'(i);
			end
			if (!slot_valid_q[i]) begin
				free_idx = IDX_W'(i);
			end
			if (exp_hit[i]) begin
				exp_idx = IDX_W'(i);
			end
		end
	end

	assign seq_any  = |seq_hit;
	assign free_any = !(&slot_valid_q);
	assign exp_any  = |exp_hit;
	assign pick_idx = seq_any ? seq_idx : free_idx;

	assign in_order = (item_q.seq_number == expected_q);
	assign early    = (item_q.seq_number > expected_q);
	assign out_free = !res_valid_q || !res_stall;

	assign rd_slot = slot_data_t'(rd_raw);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (head_valid) begin
					state_d = ST_EVAL;
				end
			end
			ST_EVAL: begin
				if (out_free) begin
					if (in_order && (item_q.payload_length != '0)) begin
						state_d = ST_SEARCH;
					end else begin
						state_d = ST_ACK;
					end
				end
			end
			ST_SEARCH: begin
				state_d = exp_any ? ST_DELIV : ST_ACK;
			end
			ST_DELIV: begin
				if (out_free) begin
					// zero length stops the drain
					state_d = (rd_slot.length != '0) ? ST_SEARCH : ST_ACK;
				end
			end
			ST_ACK: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		pop          = (state_q == ST_IDLE) && head_valid;
		do_eval      = (state_q == ST_EVAL) && out_free;
		store        = do_eval && early && (seq_any || free_any);
		drop_set     = do_eval && early && !(seq_any || free_any);
		deliver_item = do_eval && in_order;
		read_slot    = (state_q == ST_SEARCH) && exp_any;
		deliver_slot = (state_q == ST_DELIV) && out_free;
		send_ack     = (state_q == ST_ACK) && out_free;
		deliver_any  = deliver_item || deliver_slot;
		emit         = deliver_any || send_ack;

		del_len = deliver_item ? item_q.payload_length : rd_slot.length;
		del_fin = deliver_item ? item_q.final_segment : rd_slot.fin;

		emit_data = '0;
		if (send_ack) begin
			emit_data.result_kind   = RES_ACK;
			emit_data.ack_number    = expected_q;
			emit_data.dropped       = drop_q;
			emit_data.transfer_done = finished_q;
			emit_data.last_result   = 1'b1;
		end else begin
			emit_data.result_kind    = RES_DELIVER;
			emit_data.deliver_tag    = deliver_item ? item_q.payload_tag : rd_slot.tag;
			emit_data.deliver_length = del_len;
			emit_data.deliver_fin    = del_fin;
		end

		wr_slot.length = item_q.payload_length;
		wr_slot.tag    = item_q.payload_tag;
		wr_slot.fin    = item_q.final_segment;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			expected_q   <= '0;
			finished_q   <= 1'b0;
			drop_q       <= 1'b0;
			slot_valid_q <= '0;
			res_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (pop) begin
				drop_q <= 1'b0;
			end else if (drop_set) begin
				drop_q <= 1'b1;
			end
			if (deliver_any) begin
				expected_q <= expected_q + SEQ_W'(del_len);
				if (del_fin) begin
					finished_q <= 1'b1;
				end
			end
			if (deliver_item) begin
				slot_valid_q <= slot_valid_q & ~seq_hit;
			end else if (store) begin
				slot_valid_q[pick_idx] <= 1'b1;
			end else if (read_slot) begin
				slot_valid_q[exp_idx] <= 1'b0;
			end
			if (emit) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			item_q <= head;
		end
		if (store) begin
			slot_seq_q[pick_idx] <= item_q.seq_number;
		end
		if (emit) begin
			res_q <= emit_data;
		end
	end

	srr_ram #(
		.WIDTH($bits(slot_data_t)),
		.DEPTH(N)
	) u_slot_ram (
		.clk     (clk),
		.wr_en   (store),
		.wr_addr (pick_idx),
		.wr_data (wr_slot),
		.rd_en   (read_slot),
		.rd_addr (exp_idx),
		.rd_data (rd_raw)
	);

	assign res_valid = res_valid_q;
	assign res       = res_q;
endmodule
